[rtl/core/rau_pkg.sv]
package rau_pkg;

  // Every operand field travels at a fixed width; results are kept modulo 2^64.
  localparam int FIELD_BITS    = 32;
  localparam int RES_BITS      = 64;
  localparam int KIND_BITS     = 3;
  localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
  localparam int OUT_DATA_BITS = 136;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_REDUCE = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_NEGATE = 3'd5,
    KIND_CMP    = 3'd6
  } kind_t;

endpackage

[rtl/core/rau_mul.sv]
module rau_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           load,
  input  logic           step,
  input  logic           last,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] prod
);

  logic [2*W-1:0] mcand_r;
  logic [2*W-1:0] acc_r;
  logic [2*W-1:0] acc_nxt;
  logic [W-1:0]   mplier_r;
  logic [2*W-1:0] addend;

  // One multiplier bit per cycle while step is high, lowest first. The top bit of a
  // two's complement multiplier carries negative weight, so the last step subtracts.
  always_comb begin
    addend  = mplier_r[0] ? mcand_r : '0;
    acc_nxt = last ? (acc_r - addend) : (acc_r + addend);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mcand_r  <= {{W{a[W-1]}}, a};
      mplier_r <= b;
      acc_r    <= '0;
    end else if (step) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[2*W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[W-1:1]};
    end
  end

  assign prod = acc_r;

endmodule

[rtl/core/rau_reduce.sv]
module rau_reduce #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] mn,
  input  logic [W-1:0] md,
  output logic         done,
  output logic [W-1:0] qn,
  output logic [W-1:0] qd
);

  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_GCD  = 3'b010,
    R_DIV  = 3'b100
  } rstate_t;

  rstate_t        state_r;
  logic           done_r;
  logic [W-1:0]   u_r;
  logic [W-1:0]   v_r;
  logic [W-1:0]   sn_r;
  logic [W-1:0]   sd_r;
  logic [W-1:0]   g_r;
  logic [W-1:0]   rem_n_r;
  logic [W-1:0]   rem_d_r;
  logic [CW-1:0]  cnt_r;
  logic           u_ge_v;
  logic [W-1:0]   diff;
  logic [2*W-1:0] step_n;
  logic [2*W-1:0] step_d;
  logic           gcd_end;

  // One restoring division step: returns {remainder, dividend with quotient bit}.
  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                              input logic [W-1:0] dvd,
                                              input logic [W-1:0] dvs);
    logic [W:0] t;
    logic [W:0] s;
    t = {rem, dvd[W-1]};
    s = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      div_step = {s[W-1:0], dvd[W-2:0], 1'b1};
    end else begin
      div_step = {t[W-1:0], dvd[W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    u_ge_v  = (u_r >= v_r);
    diff    = u_ge_v ? (u_r - v_r) : (v_r - u_r);
    gcd_end = (u_r == '0) || (v_r == '0);
    step_n  = div_step(rem_n_r, sn_r, g_r);
    step_d  = div_step(rem_d_r, sd_r, g_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        R_IDLE: begin
          if (start) state_r <= R_GCD;
        end
        R_GCD: begin
          if (gcd_end) state_r <= R_DIV;
        end
        R_DIV: begin
          if (cnt_r == '0) begin
            state_r <= R_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  // Binary gcd. Common factors of two are taken out of the dividends as they
  // are found, so the dividends only need division by the odd part left over.
  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        if (start) begin
          u_r  <= mn;
          v_r  <= md;
          sn_r <= mn;
          sd_r <= md;
        end
      end
      R_GCD: begin
        if (gcd_end) begin
          g_r     <= (u_r == '0) ? v_r : u_r;
          rem_n_r <= '0;
          rem_d_r <= '0;
          cnt_r   <= CW'(W - 1);
        end else if (!u_r[0] && !v_r[0]) begin
          u_r  <= {1'b0, u_r[W-1:1]};
          v_r  <= {1'b0, v_r[W-1:1]};
          sn_r <= {1'b0, sn_r[W-1:1]};
          sd_r <= {1'b0, sd_r[W-1:1]};
        end else if (!u_r[0]) begin
          u_r <= {1'b0, u_r[W-1:1]};
        end else if (!v_r[0]) begin
          v_r <= {1'b0, v_r[W-1:1]};
        end else if (u_ge_v) begin
          u_r <= {1'b0, diff[W-1:1]};
        end else begin
          v_r <= {1'b0, diff[W-1:1]};
        end
      end
      R_DIV: begin
        {rem_n_r, sn_r} <= step_n;
        {rem_d_r, sd_r} <= step_d;
        cnt_r           <= cnt_r - 1'b1;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign done = done_r;
  assign qn   = sn_r;
  assign qd   = sd_r;

endmodule

[rtl/core/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit. Each input beat carries an operation kind on
// in_tuser and two fractions a_num/a_den and b_num/b_den on in_tdata; one
// result beat comes out for every input beat. The block works on one item at
// a time. Add, subtract, multiply, divide and compare run three bit-serial
// multipliers side by side, one multiplier bit per cycle. Reduce and negate
// run a binary gcd (one shift or subtract-and-shift step per cycle) followed
// by two restoring dividers working in parallel, one quotient bit per cycle;
// a zero denominator skips that work, as does the unused kind code. A new
// item is accepted while the previous result still waits in the output
// register. Only the low OPERAND_BITS bits of each operand are used,
// sign-extended from there.
module rational_arithmetic_unit_top #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
  input  logic [rau_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // kind [2:0]
  input  logic [rau_pkg::KIND_BITS-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // res_num [63:0], res_den [127:64], is_less [128], is_equal [129],
  // is_greater [130], zero fill [135:131]
  output logic [rau_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // den_zero [0]
  output logic [0:0]                         out_tuser
);

  import rau_pkg::*;

  localparam int P  = OPERAND_BITS;
  localparam int CW = $clog2(P);
  localparam int PAD_BITS = OUT_DATA_BITS - 2 * RES_BITS - 3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_RED  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  cnt_r;
  kind_t          kind_r;
  logic           neg_r;
  logic           num_nz_r;
  logic           dz_r;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                     out_dz_r;

  kind_t          kind_in;
  logic [P-1:0]   an_in;
  logic [P-1:0]   ad_in;
  logic [P-1:0]   bn_in;
  logic [P-1:0]   bd_in;
  logic [P-1:0]   an_mag;
  logic [P-1:0]   ad_mag;
  logic           neg_in;
  logic           is_red_in;
  logic           is_mul_in;
  logic           den_zero_in;
  logic           accept;
  logic           red_start;
  logic           load_out;

  logic [2*P-1:0] prod0;
  logic [2*P-1:0] prod1;
  logic [2*P-1:0] prod2;
  logic           red_done;
  logic [P-1:0]   red_qn;
  logic [P-1:0]   red_qd;

  logic [RES_BITS-1:0] x64;
  logic [RES_BITS-1:0] y64;
  logic [RES_BITS-1:0] z64;
  logic [RES_BITS-1:0] qn64;
  logic [RES_BITS-1:0] rn;
  logic [RES_BITS-1:0] rd;
  logic                lt;
  logic                eq;
  logic                gt;
  logic                dz;

  always_comb begin
    kind_in = kind_t'(in_tuser);
    an_in   = in_tdata[P-1:0];
    ad_in   = in_tdata[FIELD_BITS+P-1:FIELD_BITS];
    bn_in   = in_tdata[2*FIELD_BITS+P-1:2*FIELD_BITS];
    bd_in   = in_tdata[3*FIELD_BITS+P-1:3*FIELD_BITS];
    an_mag  = an_in[P-1] ? (P'(0) - an_in) : an_in;
    ad_mag  = ad_in[P-1] ? (P'(0) - ad_in) : ad_in;
    // Negate flips the numerator sign; a zero numerator gives zero either way.
    neg_in  = ((kind_in == KIND_NEGATE) ? (!an_in[P-1] && (an_in != '0)) : an_in[P-1])
              ^ ad_in[P-1];
    is_red_in   = (kind_in == KIND_REDUCE) || (kind_in == KIND_NEGATE);
    is_mul_in   = (kind_in == KIND_ADD) || (kind_in == KIND_SUB) || (kind_in == KIND_MUL) ||
                  (kind_in == KIND_DIV) || (kind_in == KIND_CMP);
    den_zero_in = (ad_in == '0);
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign red_start = accept && is_red_in && !den_zero_in;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Lane 0 gives a_num times b_num for multiply and a_num times b_den
  // otherwise; lane 1 gives a_den times b_num; lane 2 gives a_den times b_den.
  rau_mul #(.W(P)) u_mul0 (
    .clk  (clk),
    .load (accept),
    .step (state_r == S_MUL),
    .last (cnt_r == '0),
    .a    (an_in),
    .b    ((kind_in == KIND_MUL) ? bn_in : bd_in),
    .prod (prod0)
  );

  rau_mul #(.W(P)) u_mul1 (
    .clk  (clk),
    .load (accept),
    .step (state_r == S_MUL),
    .last (cnt_r == '0),
    .a    (ad_in),
    .b    (bn_in),
    .prod (prod1)
  );

  rau_mul #(.W(P)) u_mul2 (
    .clk  (clk),
    .load (accept),
    .step (state_r == S_MUL),
    .last (cnt_r == '0),
    .a    (ad_in),
    .b    (bd_in),
    .prod (prod2)
  );

  rau_reduce #(.W(P)) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .mn    (an_mag),
    .md    (ad_mag),
    .done  (red_done),
    .qn    (red_qn),
    .qd    (red_qd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (is_mul_in) begin
              state_r <= S_MUL;
            end else if (is_red_in && !den_zero_in) begin
              state_r <= S_RED;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          if (cnt_r == '0) state_r <= S_DONE;
        end
        S_RED: begin
          if (red_done) state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_in;
      neg_r    <= neg_in;
      num_nz_r <= (an_in != '0);
      dz_r     <= den_zero_in;
      cnt_r    <= CW'(P - 1);
    end else if (state_r == S_MUL) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Result selection once the serial units have settled.
  always_comb begin
    x64  = RES_BITS'($signed(prod0));
    y64  = RES_BITS'($signed(prod1));
    z64  = RES_BITS'($signed(prod2));
    qn64 = RES_BITS'(red_qn);
    rn   = '0;
    rd   = '0;
    lt   = 1'b0;
    eq   = 1'b0;
    gt   = 1'b0;
    dz   = 1'b0;
    case (kind_r)
      KIND_REDUCE, KIND_NEGATE: begin
        if (dz_r) begin
          rn = RES_BITS'(num_nz_r);
          dz = 1'b1;
        end else begin
          rn = neg_r ? (RES_BITS'(0) - qn64) : qn64;
          rd = RES_BITS'(red_qd);
        end
      end
      KIND_ADD: begin
        rn = x64 + y64;
        rd = z64;
        dz = (z64 == '0);
      end
      KIND_SUB: begin
        rn = x64 - y64;
        rd = z64;
        dz = (z64 == '0);
      end
      KIND_MUL: begin
        rn = x64;
        rd = z64;
        dz = (z64 == '0);
      end
      KIND_DIV: begin
        rn = x64;
        rd = y64;
        dz = (y64 == '0);
      end
      KIND_CMP: begin
        lt = ($signed(x64) < $signed(y64));
        gt = ($signed(y64) < $signed(x64));
        eq = (x64 == y64);
      end
      default: begin
        rn = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {{PAD_BITS{1'b0}}, gt, eq, lt, rd, rn};
      out_dz_r   <= dz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dz_r;

endmodule

[rtl/core/rau_checker.sv]
module rau_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rau_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input logic [0:0]                         out_tuser
);

  import rau_pkg::*;

  logic [2:0] flags;
  assign flags = out_tdata[2*RES_BITS+2:2*RES_BITS];

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // One item at a time: the input side closes right after a beat is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // At most one compare flag is set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(flags))
    else $error("more than one compare flag set");

  // A compare result carries no fraction and no zero-denominator flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (flags != 3'b000) |->
      (out_tdata[2*RES_BITS-1:0] == '0) && (out_tuser == 1'b0))
    else $error("compare result with fraction bits set");

  // A set zero-denominator flag comes with a zero denominator field.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[2*RES_BITS-1:RES_BITS] == '0))
    else $error("zero-denominator flag with nonzero denominator");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import rau_pkg::*;

  localparam int OPERAND_BITS = 32;
  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BEATS = 1200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int SHOW_LIMIT = 10;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 3'd7;
  localparam logic [31:0] OP_MAX = 32'h7fff_ffff;
  localparam logic [31:0] OP_MIN = 32'h8000_0000;

  // Flag groups in the order {is_less, is_equal, is_greater, den_zero}.
  localparam logic [3:0] F_NONE = 4'b0000;
  localparam logic [3:0] F_DZ   = 4'b0001;
  localparam logic [3:0] F_GT   = 4'b0010;
  localparam logic [3:0] F_EQ   = 4'b0100;
  localparam logic [3:0] F_LT   = 4'b1000;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } frac_result_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]    kind;
    logic [IN_DATA_BITS-1:0] data;
    logic                    typed;
    frac_result_t            want;
  } op_beat_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic [KIND_BITS-1:0]     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [0:0]               out_tuser;

  op_beat_t     op_beats[$];
  frac_result_t pending_fracs[$];
  frac_result_t seen_frac;
  frac_result_t due_frac;
  int           test_phase = 0;
  int           sent_count = 0;
  int           hold_at = 32'h7fff_ffff;
  int           fail_count = 0;
  int           checked_count = 0;
  int           quiet_cycles = 0;
  int           kind_count[8];

  rational_arithmetic_unit_top #(.OPERAND_BITS(OPERAND_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [63:0] widen(logic [31:0] v);
    logic [63:0] mask;
    logic [63:0] m;
    mask = (64'd1 << OPERAND_BITS) - 64'd1;
    m = {32'd0, v} & mask;
    if (m[OPERAND_BITS-1]) m = m | ~mask;
    return m;
  endfunction

  // Euclidean gcd on magnitudes; the sign goes to the numerator.
  function automatic frac_result_t lowest_terms(logic [63:0] n, logic [63:0] d);
    frac_result_t r;
    logic [63:0] mn, md, x, y, t;
    r = '0;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    if (md == 64'd0) begin
      r.num = (mn != 64'd0) ? 64'd1 : 64'd0;
    end else begin
      x = mn;
      y = md;
      while (y != 64'd0) begin
        t = x % y;
        x = y;
        y = t;
      end
      r.num = (n[63] ^ d[63]) ? -(mn / x) : (mn / x);
      r.den = md / x;
    end
    return r;
  endfunction

  function automatic frac_result_t predict_rational(logic [KIND_BITS-1:0] kind,
                                                    logic [IN_DATA_BITS-1:0] data);
    frac_result_t r;
    logic [63:0] an, ad, bn, bd, x, y;
    an = widen(data[31:0]);
    ad = widen(data[63:32]);
    bn = widen(data[95:64]);
    bd = widen(data[127:96]);
    x = an * bd;
    y = ad * bn;
    r = '0;
    case (kind)
      KIND_REDUCE: r = lowest_terms(an, ad);
      KIND_NEGATE: r = lowest_terms(-an, ad);
      KIND_ADD: begin
        r.num = x + y;
        r.den = ad * bd;
      end
      KIND_SUB: begin
        r.num = x - y;
        r.den = ad * bd;
      end
      KIND_MUL: begin
        r.num = an * bn;
        r.den = ad * bd;
      end
      KIND_DIV: begin
        r.num = x;
        r.den = y;
      end
      KIND_CMP: begin
        // Raw cross products, no correction for negative denominators.
        r.lt = $signed(x) < $signed(y);
        r.gt = $signed(y) < $signed(x);
        r.eq = (x == y);
      end
      default: r = '0;
    endcase
    if (kind != KIND_CMP && kind != KIND_UNUSED) r.dz = (r.den == 64'd0);
    return r;
  endfunction

  function automatic op_beat_t calc_row(logic [KIND_BITS-1:0] kind, logic [31:0] an,
                                        logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    op_beat_t b;
    b = '0;
    b.kind = kind;
    b.data = {bd, bn, ad, an};
    return b;
  endfunction

  function automatic op_beat_t lit_row(logic [KIND_BITS-1:0] kind, logic [31:0] an,
                                       logic [31:0] ad, logic [31:0] bn, logic [31:0] bd,
                                       logic [63:0] num, logic [63:0] den, logic [3:0] flags);
    op_beat_t b;
    b = calc_row(kind, an, ad, bn, bd);
    b.typed = 1'b1;
    b.want.num = num;
    b.want.den = den;
    {b.want.lt, b.want.eq, b.want.gt, b.want.dz} = flags;
    return b;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return 32'($urandom_range(0, 200)) - 32'd100;
      5: begin
        case ($urandom_range(0, 4))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return '1;
          3:       return OP_MAX;
          default: return OP_MIN;
        endcase
      end
      default: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 15);
    endcase
  endfunction

  function automatic bit note_failure();
    fail_count++;
    return fail_count <= SHOW_LIMIT;
  endfunction

  initial begin : stimulus
    op_beat_t           b;
    logic [KIND_BITS-1:0] k;
    logic [31:0]        an, ad, bn, bd, f;
    int                 snd_pct;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    foreach (kind_count[i]) kind_count[i] = 0;

    op_beats.push_back(lit_row(KIND_REDUCE, 32'd6, 32'd4, 32'd0, 32'd0, 64'd3, 64'd2, F_NONE));
    op_beats.push_back(lit_row(KIND_REDUCE, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0, F_DZ));
    op_beats.push_back(lit_row(KIND_REDUCE, 32'd5, 32'd0, 32'd0, 32'd0, 64'd1, 64'd0, F_DZ));
    op_beats.push_back(lit_row(KIND_REDUCE, -32'd6, -32'd4, 32'd0, 32'd0, 64'd3, 64'd2,
                               F_NONE));
    op_beats.push_back(lit_row(KIND_REDUCE, 32'd6, -32'd4, 32'd0, 32'd0, -64'd3, 64'd2,
                               F_NONE));
    op_beats.push_back(calc_row(KIND_REDUCE, OP_MIN, 32'd1, '1, '1));
    op_beats.push_back(calc_row(KIND_REDUCE, 32'd1, OP_MIN, OP_MAX, OP_MAX));
    op_beats.push_back(lit_row(KIND_REDUCE, OP_MIN, OP_MIN, 32'd0, 32'd0, 64'd1, 64'd1,
                               F_NONE));
    op_beats.push_back(calc_row(KIND_MUL, OP_MIN, OP_MAX, OP_MIN, OP_MIN));
    op_beats.push_back(lit_row(KIND_NEGATE, 32'd0, 32'd7, 32'd0, 32'd0, 64'd0, 64'd1, F_NONE));
    op_beats.push_back(calc_row(KIND_NEGATE, OP_MIN, 32'd3, 32'd0, 32'd0));
    op_beats.push_back(lit_row(KIND_NEGATE, 32'd4, 32'd0, 32'd0, 32'd0, 64'd1, 64'd0, F_DZ));
    op_beats.push_back(lit_row(KIND_NEGATE, -32'd5, 32'd0, 32'd0, 32'd0, 64'd1, 64'd0, F_DZ));
    op_beats.push_back(calc_row(KIND_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX));
    // Two products of 2^62 sum to 2^63 and wrap to the most negative value.
    op_beats.push_back(calc_row(KIND_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN));
    op_beats.push_back(lit_row(KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd3, 64'd1, 64'd6, F_NONE));
    op_beats.push_back(lit_row(KIND_MUL, 32'd3, 32'd0, 32'd2, 32'd5, 64'd6, 64'd0, F_DZ));
    op_beats.push_back(lit_row(KIND_DIV, 32'd1, 32'd2, 32'd0, 32'd3, 64'd3, 64'd0, F_DZ));
    op_beats.push_back(calc_row(KIND_DIV, OP_MIN, '1, OP_MAX, OP_MIN));
    op_beats.push_back(lit_row(KIND_CMP, 32'd1, 32'd2, 32'd1, 32'd3, 64'd0, 64'd0, F_GT));
    op_beats.push_back(lit_row(KIND_CMP, 32'd2, 32'd4, 32'd1, 32'd2, 64'd0, 64'd0, F_EQ));
    op_beats.push_back(lit_row(KIND_CMP, 32'd1, 32'd3, 32'd1, 32'd2, 64'd0, 64'd0, F_LT));
    op_beats.push_back(calc_row(KIND_CMP, 32'd1, -32'd2, 32'd1, 32'd3));
    op_beats.push_back(lit_row(KIND_UNUSED, '1, '1, '1, '1, 64'd0, 64'd0, F_NONE));
    op_beats.push_back(lit_row(KIND_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0, F_DZ));

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      k = ($urandom_range(0, 15) == 0) ? KIND_UNUSED : 3'($urandom_range(0, 6));
      an = pick_operand();
      ad = pick_operand();
      bn = pick_operand();
      bd = pick_operand();
      // Most fractions are well formed, with positive denominators.
      if (k != KIND_UNUSED && $urandom_range(0, 3) != 0) begin
        ad[31] = 1'b0;
        bd[31] = 1'b0;
        if (ad == 32'd0) ad = 32'd1;
        if (bd == 32'd0) bd = 32'd1;
      end
      // Give reduce and negate a common factor to remove.
      if ((k == KIND_REDUCE || k == KIND_NEGATE) && $urandom_range(0, 1) == 1) begin
        f = 32'($urandom_range(1, 5000));
        an = f * (32'($urandom_range(0, 2000)) - 32'd1000);
        ad = f * 32'($urandom_range(1, 2000));
        if ($urandom_range(0, 3) == 0) ad = -ad;
      end
      op_beats.push_back(calc_row(k, an, ad, bn, bd));
    end
    hold_at = op_beats.size() * 5 / 6;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int idx = 0; idx < op_beats.size(); idx++) begin
      b = op_beats[idx];
      test_phase = idx * 3 / op_beats.size();
      snd_pct = (test_phase == 0) ? 13 : (test_phase == 1) ? 49 : 0;
      while ($urandom_range(0, 99) < snd_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= b.data;
      in_tuser <= b.kind;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      pending_fracs.push_back(b.typed ? b.want : predict_rational(b.kind, b.data));
      kind_count[b.kind]++;
      sent_count++;
    end
    in_tvalid <= 1'b0;

    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand beats (%0d reduce, %0d negate, %0d compare, %0d unused code),",
             sent_count, kind_count[KIND_REDUCE], kind_count[KIND_NEGATE],
             kind_count[KIND_CMP], kind_count[KIND_UNUSED]);
    $display("checked %0d results under three stall mixes and a long output hold; %0d failed.",
             checked_count, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : sink
    bit held;
    int rcv_pct;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      // One long hold-off while the sender keeps offering beats.
      if (!held && sent_count >= hold_at) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rcv_pct = (test_phase == 0) ? 49 : (test_phase == 1) ? 13 : 0;
      out_tready <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_frac.num = out_tdata[63:0];
      seen_frac.den = out_tdata[127:64];
      seen_frac.lt = out_tdata[128];
      seen_frac.eq = out_tdata[129];
      seen_frac.gt = out_tdata[130];
      seen_frac.dz = out_tuser[0];
      checked_count++;
      if (pending_fracs.size() == 0) begin
        if (note_failure())
          $display("Unexpected result beat %0d: num %h den %h flags %b%b%b dz %b",
                   checked_count, seen_frac.num, seen_frac.den, seen_frac.lt,
                   seen_frac.eq, seen_frac.gt, seen_frac.dz);
      end else begin
        due_frac = pending_fracs.pop_front();
        if (seen_frac.num !== due_frac.num || seen_frac.den !== due_frac.den ||
            seen_frac.lt !== due_frac.lt || seen_frac.eq !== due_frac.eq ||
            seen_frac.gt !== due_frac.gt || seen_frac.dz !== due_frac.dz) begin
          if (note_failure()) begin
            $display("Mismatch on result %0d (expected/actual): num %h/%h den %h/%h",
                     checked_count, due_frac.num, seen_frac.num, due_frac.den,
                     seen_frac.den);
            $display("  lt %b/%b eq %b/%b gt %b/%b den_zero %b/%b",
                     due_frac.lt, seen_frac.lt, due_frac.eq, seen_frac.eq,
                     due_frac.gt, seen_frac.gt, due_frac.dz, seen_frac.dz);
          end
        end
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout with %0d results still outstanding", pending_fracs.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
